[rtl/elwa_pkg.sv]
// Shared widths, register indexes and reset values for the eased LED wipe animator.
`timescale 1ns / 1ps
`default_nettype none

package elwa_pkg;

    localparam int TIME_W   = 32;
    localparam int ANIM_W   = 16;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int COLOR_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int Q16_W   = 17;
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [COUNT_W-1:0] MAX_PIXELS = 11'd1024;
    localparam logic [Q16_W-1:0]   Q16_ONE    = 17'h10000;

    // Command codes on the input channel
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_RED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_GREEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_BLUE    = 3'd4;

    // Configuration reset values
    localparam logic [ANIM_W-1:0]  DURATION_RST    = 16'd500;
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 11'd16;
    localparam logic [COLOR_W-1:0] LIT_COLOR_RST   = 8'd255;

    localparam logic [COLOR_W-1:0] BLACK = 8'd0;

endpackage

`default_nettype wire

[rtl/elwa_if.sv]
// Valid/ready channel interfaces for tick/query items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface elwa_in_if;
    import elwa_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [TIME_W-1:0]  now_ms;
    logic               target_on;
    logic [INDEX_W-1:0] pixel_index;

    modport source (output valid, output command, output now_ms, output target_on,
                    output pixel_index, input ready);
    modport sink   (input valid, input command, input now_ms, input target_on,
                    input pixel_index, output ready);
endinterface

interface elwa_out_if;
    import elwa_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] lit_length;
    logic               length_changed;
    logic               active;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;

    modport source (output valid, output lit_length, output length_changed, output active,
                    output pixel_red, output pixel_green, output pixel_blue, input ready);
    modport sink   (input valid, input lit_length, input length_changed, input active,
                    input pixel_red, input pixel_green, input pixel_blue, output ready);
endinterface

`default_nettype wire

[rtl/eased_led_wipe_animator_top.sv]
// Top level of the eased LED wipe animator: tick/query sequencer, divider and shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transfer when         Payload
// in_ch     in   valid & ready         command, now_ms, target_on, pixel_index
// out_ch    out  valid & ready         lit_length, length_changed, active, pixel rgb
// cfg       in   cfg_we (no handshake) cfg_index, cfg_data
//
// A query goes from IDLE through FIN to the output register, as does a
// tick that leaves the animation time where it was. A tick that moves it
// passes a setup state (PREP), then 16 restoring-divide steps for
// t = anim*65536/duration (skipped when anim >= duration), then three passes
// through the one shared 31x16 multiplier (x^2, x^3, eased*pixels).
// Reset clears state and config to defaults; no clearing pass is needed.
// in_ch.ready is high only while the sequencer is idle. A finished result
// waits in the FIN state while out_ch holds a result that is not yet taken.

module eased_led_wipe_animator_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    elwa_in_if.sink                           in_ch,
    elwa_out_if.source                        out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [elwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [elwa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import elwa_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_XSEL  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_CUBE  = 4'd5;
    localparam logic [3:0] S_EASE  = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // Configuration registers
    logic [ANIM_W-1:0]  duration_reg;
    logic [COUNT_W-1:0] pixel_count_reg;
    logic [COLOR_W-1:0] lit_red_reg;
    logic [COLOR_W-1:0] lit_green_reg;
    logic [COLOR_W-1:0] lit_blue_reg;

    // Animation state
    logic [TIME_W-1:0]  last_tick_reg;
    logic [ANIM_W-1:0]  anim_reg;
    logic [COUNT_W-1:0] lit_count_reg;

    // Sequencer and datapath
    logic [3:0]         state_reg;
    logic               calc_reg;
    logic [ANIM_W-1:0]  rem_reg;
    logic [3:0]         cnt_reg;
    logic [Q16_W-1:0]   t_reg;
    logic [ANIM_W-1:0]  x_reg;
    logic               lo_reg;
    logic [Q16_W-1:0]   eased_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;

    // Output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_len_reg;
    logic               out_changed_reg;
    logic               out_active_reg;
    logic [COLOR_W-1:0] out_red_reg;
    logic [COLOR_W-1:0] out_green_reg;
    logic [COLOR_W-1:0] out_blue_reg;

    // Effective config: zero duration acts as 1, pixels clamp to 1..1024
    logic [ANIM_W-1:0]  dur_eff;
    logic [COUNT_W-1:0] pix_eff;

    always_comb
    begin
        dur_eff = (duration_reg == '0) ? ANIM_W'(1) : duration_reg;
        if (pixel_count_reg == '0)
            pix_eff = COUNT_W'(1);
        else if (pixel_count_reg > MAX_PIXELS)
            pix_eff = MAX_PIXELS;
        else
            pix_eff = pixel_count_reg;
    end

    // Tick update of the animation time
    logic [TIME_W-1:0]  delta;
    logic [TIME_W:0]    sum;
    logic [ANIM_W-1:0]  anim_tick;
    logic               moved;

    always_comb
    begin
        delta     = in_ch.now_ms - last_tick_reg;
        sum       = {{(TIME_W-ANIM_W+1){1'b0}}, anim_reg} + {1'b0, delta};
        anim_tick = anim_reg;
        moved     = 1'b0;
        if (in_ch.target_on)
        begin
            if (anim_reg != duration_reg)
            begin
                moved = 1'b1;
                if (sum > {{(TIME_W-ANIM_W+1){1'b0}}, duration_reg})
                    anim_tick = duration_reg;
                else
                    anim_tick = sum[ANIM_W-1:0];
            end
        end
        else if (anim_reg != '0)
        begin
            moved = 1'b1;
            if ({{(TIME_W-ANIM_W){1'b0}}, anim_reg} > delta)
                anim_tick = anim_reg - delta[ANIM_W-1:0];
            else
                anim_tick = '0;
        end
    end

    // Restoring divide step: dividend is anim << 16, so zeros shift in
    logic [ANIM_W:0]   rem_shift;
    logic              div_bit;
    logic [ANIM_W:0]   rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        div_bit   = (rem_shift >= {1'b0, dur_eff});
        rem_sub   = rem_shift - {1'b0, dur_eff};
    end

    // Shared multiplier operand select
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ANIM_W-1:0]  cube_hi;

    always_comb
    begin
        mul_a = {{(MUL_A_W-ANIM_W){1'b0}}, x_reg};
        mul_b = x_reg;
        case (state_reg)
            S_CUBE:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = x_reg;
            end
            S_SCALE:
            begin
                mul_a = {{(MUL_A_W-Q16_W){1'b0}}, eased_reg};
                mul_b = {{(MUL_B_W-COUNT_W){1'b0}}, pix_eff};
            end
            default:
            begin
                mul_a = {{(MUL_A_W-ANIM_W){1'b0}}, x_reg};
                mul_b = x_reg;
            end
        endcase
        // x^3 >> 30, at most 32768
        cube_hi = prod_reg[30 +: ANIM_W];
    end

    logic [COUNT_W-1:0] new_len;
    logic               out_free;

    assign new_len  = prod_reg[16 +: COUNT_W];
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.lit_length     = out_len_reg;
    assign out_ch.length_changed = out_changed_reg;
    assign out_ch.active         = out_active_reg;
    assign out_ch.pixel_red      = out_red_reg;
    assign out_ch.pixel_green    = out_green_reg;
    assign out_ch.pixel_blue     = out_blue_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg    <= DURATION_RST;
            pixel_count_reg <= PIXEL_COUNT_RST;
            lit_red_reg     <= LIT_COLOR_RST;
            lit_green_reg   <= LIT_COLOR_RST;
            lit_blue_reg    <= LIT_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DURATION:    duration_reg    <= cfg_data[ANIM_W-1:0];
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_LIT_RED:     lit_red_reg     <= cfg_data[COLOR_W-1:0];
                CFG_LIT_GREEN:   lit_green_reg   <= cfg_data[COLOR_W-1:0];
                CFG_LIT_BLUE:    lit_blue_reg    <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            calc_reg      <= 1'b0;
            cnt_reg       <= '0;
            last_tick_reg <= '0;
            anim_reg      <= '0;
            lit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads as the old one leaves
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (in_ch.command == CMD_TICK)
                        begin
                            last_tick_reg <= in_ch.now_ms;
                            anim_reg      <= anim_tick;
                            calc_reg      <= moved;
                            state_reg     <= moved ? S_PREP : S_FIN;
                        end
                        else
                        begin
                            calc_reg  <= 1'b0;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (anim_reg >= dur_eff) ? S_XSEL : S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_XSEL;
                end
                S_XSEL:  state_reg <= S_SQ;
                S_SQ:    state_reg <= S_CUBE;
                S_CUBE:  state_reg <= S_EASE;
                S_EASE:  state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        if (calc_reg)
                            lit_count_reg <= new_len;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                red_reg   <= BLACK;
                green_reg <= BLACK;
                blue_reg  <= BLACK;
                if (in_ch.command == CMD_QUERY &&
                    {1'b0, in_ch.pixel_index} < lit_count_reg)
                begin
                    red_reg   <= lit_red_reg;
                    green_reg <= lit_green_reg;
                    blue_reg  <= lit_blue_reg;
                end
            end
            S_PREP:
            begin
                rem_reg <= anim_reg;
                // anim >= duration saturates t at one
                t_reg   <= (anim_reg >= dur_eff) ? Q16_ONE : '0;
            end
            S_DIV:
            begin
                rem_reg <= div_bit ? rem_sub[ANIM_W-1:0] : rem_shift[ANIM_W-1:0];
                t_reg   <= {t_reg[Q16_W-2:0], div_bit};
            end
            S_XSEL:
            begin
                // Fold the upper half: x = 1 - t there, so both halves cube x
                if (t_reg[Q16_W-1])
                    x_reg <= '0;
                else if (t_reg[Q16_W-2])
                    x_reg <= ANIM_W'(Q16_ONE - t_reg);
                else
                    x_reg <= t_reg[ANIM_W-1:0];
                lo_reg <= !t_reg[Q16_W-1] && !t_reg[Q16_W-2];
            end
            S_SQ, S_CUBE, S_SCALE:
            begin
                prod_reg <= {{(PROD_W-MUL_A_W){1'b0}}, mul_a} *
                            {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
            end
            S_EASE:
            begin
                eased_reg <= lo_reg ? {1'b0, cube_hi} : (Q16_ONE - {1'b0, cube_hi});
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_len_reg     <= calc_reg ? new_len : lit_count_reg;
                    out_changed_reg <= calc_reg && (new_len != lit_count_reg);
                    out_active_reg  <= (anim_reg != '0);
                    out_red_reg     <= red_reg;
                    out_green_reg   <= green_reg;
                    out_blue_reg    <= blue_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
